// ----- rtl/r2as_pkg.sv -----
package r2as_pkg;

   localparam int R_W    = 17;
   localparam int CFG_W  = 24;
   localparam int OUT_W  = 26;
   localparam int PROD_W = 41;
   localparam int NUM_W  = 59;
   localparam int DEN_W  = 35;
   localparam int CMP_W  = DEN_W + OUT_W;
   localparam int IDX_W  = 1;

   localparam logic [R_W-1:0]   ONE_Q16    = 17'd65536;
   localparam logic [CFG_W-1:0] CFG_RESET  = 24'd65536;
   localparam logic [IDX_W-1:0] IDX_WHITE  = 1'd0;
   localparam logic [IDX_W-1:0] IDX_BLACK  = 1'd1;

   typedef enum logic [1:0] {
      CASE_ZERO,
      CASE_ONE,
      CASE_DARK,
      CASE_LIGHT
   } case_type;

   typedef struct packed {
      logic [NUM_W-1:0] num_k;
      logic [DEN_W-1:0] den_k;
      logic [NUM_W-1:0] num_s;
      logic [DEN_W-1:0] den_s;
   } div_req_type;

endpackage

// ----- rtl/r2as_front.sv -----
module r2as_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [r2as_pkg::CFG_W-1:0]    white_scatter,
   input  logic [r2as_pkg::CFG_W-1:0]    black_absorb,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [r2as_pkg::R_W-1:0]      in_refl,
   output logic                          out_valid,
   input  logic                          out_ready,
   output r2as_pkg::div_req_type         out_req
);

   logic [2:0] v_ff;
   logic [2:0] en;

   r2as_pkg::case_type              cs_a_ff, cs_b_ff, cs_a_in;
   logic [r2as_pkg::R_W-1:0]        r_a_ff, dr_a_ff, r_b_ff, dr_b_ff, r_a_in;
   logic [r2as_pkg::PROD_W-1:0]     pk_b_ff, ps_b_ff;
   logic [33:0]                     rr_b_ff;
   logic [r2as_pkg::CFG_W-1:0]      sel_a;
   logic [57:0]                     pk_full;
   logic [17:0]                     two_plus_r;
   logic [r2as_pkg::DEN_W-1:0]      den_light;
   r2as_pkg::div_req_type           req_in, req_ff;

   always_comb begin
      en[2] = !v_ff[2] || out_ready;
      en[1] = !v_ff[1] || en[2];
      en[0] = !v_ff[0] || en[1];
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[2];
   assign out_req   = req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_comb begin
      r_a_in = in_refl[16] ? r2as_pkg::ONE_Q16 : in_refl;
      if (r_a_in == '0) begin
         cs_a_in = r2as_pkg::CASE_ZERO;
      end else if (r_a_in == r2as_pkg::ONE_Q16) begin
         cs_a_in = r2as_pkg::CASE_ONE;
      end else if (r_a_in <= 17'd32768) begin
         cs_a_in = r2as_pkg::CASE_DARK;
      end else begin
         cs_a_in = r2as_pkg::CASE_LIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_a_ff  <= r_a_in;
         dr_a_ff <= r2as_pkg::ONE_Q16 - r_a_in;
         cs_a_ff <= cs_a_in;
      end
   end

   assign sel_a = (cs_a_ff == r2as_pkg::CASE_DARK) ? white_scatter : black_absorb;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pk_b_ff <= sel_a * dr_a_ff;
         ps_b_ff <= sel_a * r_a_ff;
         rr_b_ff <= r_a_ff * r_a_ff;
         r_b_ff  <= r_a_ff;
         dr_b_ff <= dr_a_ff;
         cs_b_ff <= cs_a_ff;
      end
   end

   always_comb begin
      pk_full    = pk_b_ff * dr_b_ff;
      two_plus_r = {1'b0, r_b_ff} + 18'd131072;
      den_light  = 35'h2_0000_0000 - {1'b0, rr_b_ff};
      case (cs_b_ff)
         r2as_pkg::CASE_ZERO: begin
            req_in.num_k = r2as_pkg::NUM_W'({black_absorb, 2'b00});
            req_in.den_k = r2as_pkg::DEN_W'(5);
            req_in.num_s = '0;
            req_in.den_s = r2as_pkg::DEN_W'(1);
         end
         r2as_pkg::CASE_ONE: begin
            req_in.num_k = '0;
            req_in.den_k = r2as_pkg::DEN_W'(1);
            req_in.num_s = r2as_pkg::NUM_W'({white_scatter, 2'b00});
            req_in.den_s = r2as_pkg::DEN_W'(5);
         end
         r2as_pkg::CASE_DARK: begin
            req_in.num_k = r2as_pkg::NUM_W'(pk_full);
            req_in.den_k = {two_plus_r, 17'd0};
            req_in.num_s = r2as_pkg::NUM_W'(ps_b_ff);
            req_in.den_s = r2as_pkg::DEN_W'(two_plus_r);
         end
         default: begin
            req_in.num_k = {pk_full, 1'b0};
            req_in.den_k = den_light;
            req_in.num_s = {ps_b_ff, 18'd0};
            req_in.den_s = den_light;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[2]) req_ff <= req_in;
   end

endmodule

// ----- rtl/r2as_div.sv -----
module r2as_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  r2as_pkg::div_req_type         in_req,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [r2as_pkg::OUT_W-1:0]    out_k,
   output logic [r2as_pkg::OUT_W-1:0]    out_s
);

   localparam int QW = r2as_pkg::OUT_W;
   localparam int NS = QW + 2;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   logic [r2as_pkg::NUM_W-1:0] rem_ff [NS][2];
   logic [r2as_pkg::DEN_W-1:0] den_ff [NS][2];
   logic [QW-1:0]              q_ff   [NS][2];
   logic                       ovf_ff [NS][2];

   logic [r2as_pkg::NUM_W-1:0] num_in [2];
   logic [r2as_pkg::DEN_W-1:0] den_in [2];

   assign num_in[0] = in_req.num_k;
   assign num_in[1] = in_req.num_s;
   assign den_in[0] = in_req.den_k;
   assign den_in[1] = in_req.den_s;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];
   assign out_k = ovf_ff[NS-1][0] ? {QW{1'b1}} : q_ff[NS-1][0];
   assign out_s = ovf_ff[NS-1][1] ? {QW{1'b1}} : q_ff[NS-1][1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      always_ff @(posedge clock) begin
         if (en[0]) begin
            rem_ff[0][l] <= num_in[l] + r2as_pkg::NUM_W'(den_in[l] >> 1);
            den_ff[0][l] <= den_in[l];
            q_ff[0][l]   <= '0;
            ovf_ff[0][l] <= 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (en[1]) begin
            rem_ff[1][l] <= rem_ff[0][l];
            den_ff[1][l] <= den_ff[0][l];
            q_ff[1][l]   <= '0;
            ovf_ff[1][l] <= r2as_pkg::CMP_W'(rem_ff[0][l]) >=
                            (r2as_pkg::CMP_W'(den_ff[0][l]) << QW);
         end
      end

      for (genvar k = 2; k < NS; k++) begin : g_bit
         localparam int B = NS - 1 - k;
         logic [r2as_pkg::CMP_W-1:0] trial;
         logic [r2as_pkg::CMP_W-1:0] rem_x;
         logic                       take;

         assign trial = r2as_pkg::CMP_W'(den_ff[k-1][l]) << B;
         assign rem_x = r2as_pkg::CMP_W'(rem_ff[k-1][l]);
         assign take  = rem_x >= trial;

         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff[k][l] <= take ? r2as_pkg::NUM_W'(rem_x - trial) : rem_ff[k-1][l];
               den_ff[k][l] <= den_ff[k-1][l];
               q_ff[k][l]   <= q_ff[k-1][l] | (QW'(take) << B);
               ovf_ff[k][l] <= ovf_ff[k-1][l];
            end
         end
      end
   end

endmodule

// ----- rtl/reflectance_to_absorption_scatter.sv -----
// Kubelka-Munk reflectance to absorption K and scattering S.
// Input channel req_: one reflectance item per transfer, unsigned Q0.16 where
// 65536 is 1.0; values above that count as 1.0.
// Result channel rsp_: one item per input, K and S as unsigned Q10.16,
// rounded to nearest (ties up) and saturated at all ones.
// Configuration csr_: index 0 writes white scattering, index 1 black
// absorption, both unsigned Q8.16; write only while no item is in flight.
// Pipeline: three front stages for clamping, products and numerator/denominator
// forming, then a restoring divider of 28 stages: rounding offset, overflow
// check and 26 stages of one quotient bit each, K and S side by side.
// Throughput: one item per cycle while rsp_tready is high.
// Reset empties the pipeline and loads 1.0 into both registers.
// When rsp_tready is low, stages behind a full stage hold while empty
// stages keep filling, so req_tready falls only once every stage is full.
module reflectance_to_absorption_scatter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // reflectance[16:0], zero fill
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [55:0]                   rsp_tdata,  // absorption[25:0], scattering[51:26], zero fill
   input  logic                          csr_wen,
   input  logic [r2as_pkg::IDX_W-1:0]    csr_index,
   input  logic [r2as_pkg::CFG_W-1:0]    csr_wdata
);

   logic [r2as_pkg::CFG_W-1:0] white_ff, black_ff;
   logic                       mid_valid, mid_ready;
   r2as_pkg::div_req_type      mid_req;
   logic [r2as_pkg::OUT_W-1:0] k_out, s_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= r2as_pkg::CFG_RESET;
         black_ff <= r2as_pkg::CFG_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            r2as_pkg::IDX_WHITE: white_ff <= csr_wdata;
            r2as_pkg::IDX_BLACK: black_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   r2as_front u_front (
      .clock         (clock),
      .reset         (reset),
      .white_scatter (white_ff),
      .black_absorb  (black_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_refl       (req_tdata[16:0]),
      .out_valid     (mid_valid),
      .out_ready     (mid_ready),
      .out_req       (mid_req)
   );

   r2as_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_req    (mid_req),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_k     (k_out),
      .out_s     (s_out)
   );

   assign rsp_tdata = {4'd0, s_out, k_out};

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output stage");

   a_drain_ready : assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output drains");

endmodule
